### rtl/nvms_pkg.sv
// Shared types and constants for the sorted nearest-value lookup block.
// Used by nvms_ctrl, nvms_dpath and nearest_value_match_sum; depends on nothing.
package nvms_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int VAL_W       = 16;
    localparam int SUM_W       = 17;
    localparam int POS_W       = 10;
    localparam int KIND_W      = 2;
    localparam int STAT_W      = 2;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_ANSWER = 2'd0,
        ST_DONE   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LREAD,
        S_LCMP,
        S_QREAD,
        S_QCMP,
        S_FREAD,
        S_FCAP,
        S_FPICK,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_PM1,
        RD_MID,
        RD_IDX,
        RD_IDXM1
    } rd_sel_t;

    typedef enum logic {
        WR_SHIFT,
        WR_KEY
    } wr_sel_t;

    typedef enum logic [1:0] {
        RES_CODE,
        RES_RDATA,
        RES_PICK
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        logic     cnt_clear;
        logic     cnt_inc;
        logic     p_init;
        logic     p_dec;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     bs_init;
        logic     bs_step;
        logic     idx_set;
        logic     cap_a;
        logic     res_load;
        res_sel_t res_sel;
        status_t  res_code;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              cnt_zero;
        logic              cnt_full;
        logic              p_zero;
        logic              shift_gt;
        logic              bs_done;
        logic              single;
        logic              out_free;
    } sts_t;

endpackage

### rtl/nearest_value_match_sum.sv
// Sorted nearest-value lookup, one transaction at a time through a single-port-pair RAM.
// Clear, unused kind, full load, empty query: DECODE goes straight to DONE.
// Load: LREAD and LCMP for each entry shifted up by the insertion, then the key write.
// Query: up to ceil(log2(count+1)) lower-bound steps, then FREAD, FCAP and maybe FPICK.
// The value RAM gives one read per cycle; the next accept follows the result.
// Reset clears the entry count and the output valid; RAM contents stay undefined.
module nearest_value_match_sum (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [nvms_pkg::KIND_W-1:0]        kind,
    input  logic signed [nvms_pkg::VAL_W-1:0]  value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [nvms_pkg::STAT_W-1:0]        status,
    output logic signed [nvms_pkg::VAL_W-1:0]  nearest,
    output logic signed [nvms_pkg::SUM_W-1:0]  match_sum,
    output logic [nvms_pkg::POS_W-1:0]         position
);

    import nvms_pkg::*;

    cmd_t cmd;
    sts_t sts;

    nvms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nvms_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .kind      (kind),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .nearest   (nearest),
        .match_sum (match_sum),
        .position  (position)
    );

endmodule

### rtl/nvms_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nvms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/nvms_ctrl.sv
// Controller state machine: sequences insertion shifts, the lower-bound
// search and the neighbor pick. Depends on nvms_pkg.
module nvms_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  nvms_pkg::sts_t sts,
    output nvms_pkg::cmd_t cmd
);

    import nvms_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.kind)
                    KIND_LOAD:  state_next = sts.cnt_full ? S_DONE : S_LREAD;
                    KIND_QUERY: state_next = sts.cnt_zero ? S_DONE : S_QREAD;
                    default:    state_next = S_DONE;
                endcase
            end
            S_LREAD:  state_next = sts.p_zero ? S_DONE : S_LCMP;
            S_LCMP:   state_next = sts.shift_gt ? S_LREAD : S_DONE;
            S_QREAD:  state_next = sts.bs_done ? S_FREAD : S_QCMP;
            S_QCMP:   state_next = S_QREAD;
            S_FREAD:  state_next = S_FCAP;
            S_FCAP:   state_next = sts.single ? S_DONE : S_FPICK;
            S_FPICK:  state_next = S_DONE;
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.rd_sel   = RD_PM1;
        cmd.wr_sel   = WR_KEY;
        cmd.res_sel  = RES_CODE;
        cmd.res_code = ST_DONE;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_DECODE:
            begin
                case (sts.kind)
                    KIND_CLEAR:
                    begin
                        cmd.cnt_clear = 1'b1;
                        cmd.res_load  = 1'b1;
                    end
                    KIND_LOAD:
                    begin
                        if (sts.cnt_full)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.p_init = 1'b1;
                        end
                    end
                    KIND_QUERY:
                    begin
                        if (sts.cnt_zero)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_code = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.bs_init = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                    end
                endcase
            end
            S_LREAD:
            begin
                if (sts.p_zero)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    cmd.res_load = 1'b1;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            S_LCMP:
            begin
                cmd.wr_en = 1'b1;
                if (sts.shift_gt)
                begin
                    // move the larger entry up one slot
                    cmd.wr_sel = WR_SHIFT;
                    cmd.p_dec  = 1'b1;
                end
                else
                begin
                    cmd.cnt_inc  = 1'b1;
                    cmd.res_load = 1'b1;
                end
            end
            S_QREAD:
            begin
                if (sts.bs_done)
                begin
                    cmd.idx_set = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_MID;
                end
            end
            S_QCMP:
            begin
                cmd.bs_step = 1'b1;
            end
            S_FREAD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX;
            end
            S_FCAP:
            begin
                if (sts.single)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_RDATA;
                    cmd.res_code = ST_ANSWER;
                end
                else
                begin
                    cmd.cap_a  = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDXM1;
                end
            end
            S_FPICK:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_PICK;
                cmd.res_code = ST_ANSWER;
            end
            S_DONE:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd.capture = 1'b0;
            end
        endcase
    end

endmodule

### rtl/nvms_dpath.sv
// Datapath: entry count, sorted value RAM, search bounds, distance compare
// and the output register. Depends on nvms_pkg and nvms_ram.
module nvms_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [nvms_pkg::KIND_W-1:0]        kind,
    input  logic signed [nvms_pkg::VAL_W-1:0]  value,
    input  nvms_pkg::cmd_t                     cmd,
    output nvms_pkg::sts_t                     sts,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [nvms_pkg::STAT_W-1:0]        status,
    output logic signed [nvms_pkg::VAL_W-1:0]  nearest,
    output logic signed [nvms_pkg::SUM_W-1:0]  match_sum,
    output logic [nvms_pkg::POS_W-1:0]         position
);

    import nvms_pkg::*;

    logic [KIND_W-1:0]       kind_reg,        kind_next;
    logic signed [VAL_W-1:0] key_reg,         key_next;
    logic [CNT_W-1:0]        cnt_reg,         cnt_next;
    logic [CNT_W-1:0]        p_reg,           p_next;
    logic [CNT_W-1:0]        lo_reg,          lo_next;
    logic [CNT_W-1:0]        hi_reg,          hi_next;
    logic [ADDR_W-1:0]       idx_reg,         idx_next;
    logic                    single_reg,      single_next;
    logic signed [VAL_W-1:0] a_reg,           a_next;
    status_t                 res_status_reg,  res_status_next;
    logic signed [VAL_W-1:0] res_nearest_reg, res_nearest_next;
    logic [ADDR_W-1:0]       res_pos_reg,     res_pos_next;
    logic                    out_valid_reg,   out_valid_next;
    logic [STAT_W-1:0]       status_reg,      status_next;
    logic signed [VAL_W-1:0] nearest_reg,     nearest_next;
    logic signed [SUM_W-1:0] sum_reg,         sum_next;
    logic [POS_W-1:0]        pos_reg,         pos_next;

    logic [VAL_W-1:0]        ram_rdata;
    logic signed [VAL_W-1:0] rdata;
    logic [ADDR_W-1:0]       raddr;
    logic [ADDR_W-1:0]       waddr;
    logic [VAL_W-1:0]        wdata;
    logic [CNT_W:0]          lohi_sum;
    logic [ADDR_W-1:0]       mid;
    logic signed [SUM_W-1:0] da_s;
    logic signed [SUM_W-1:0] db_s;
    logic [SUM_W-1:0]        da;
    logic [SUM_W-1:0]        db;
    logic                    out_free;
    logic                    lo_past_end;

    assign rdata    = $signed(ram_rdata);
    assign lohi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = ADDR_W'(lohi_sum >> 1);
    assign out_free = !out_valid_reg || out_ready;
    assign lo_past_end = (lo_reg >= cnt_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_PM1:   raddr = ADDR_W'(p_reg - CNT_W'(1));
            RD_MID:   raddr = mid;
            RD_IDX:   raddr = idx_reg;
            RD_IDXM1: raddr = idx_reg - ADDR_W'(1);
            default:  raddr = idx_reg;
        endcase
    end

    assign waddr = ADDR_W'(p_reg);
    assign wdata = (cmd.wr_sel == WR_SHIFT) ? ram_rdata : key_reg;

    nvms_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // distances from the query to the upper (a) and lower (rdata) neighbor
    assign da_s = SUM_W'(key_reg) - SUM_W'(a_reg);
    assign db_s = SUM_W'(key_reg) - SUM_W'(rdata);
    assign da   = da_s[SUM_W-1] ? SUM_W'(-da_s) : SUM_W'(da_s);
    assign db   = db_s[SUM_W-1] ? SUM_W'(-db_s) : SUM_W'(db_s);

    always_comb
    begin
        kind_next        = kind_reg;
        key_next         = key_reg;
        cnt_next         = cnt_reg;
        p_next           = p_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        idx_next         = idx_reg;
        single_next      = single_reg;
        a_next           = a_reg;
        res_status_next  = res_status_reg;
        res_nearest_next = res_nearest_reg;
        res_pos_next     = res_pos_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        nearest_next     = nearest_reg;
        sum_next         = sum_reg;
        pos_next         = pos_reg;

        if (cmd.capture)
        begin
            kind_next = kind;
            key_next  = value;
        end
        if (cmd.cnt_clear)
        begin
            cnt_next = '0;
        end
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.p_init)
        begin
            p_next = cnt_reg;
        end
        if (cmd.p_dec)
        begin
            p_next = p_reg - CNT_W'(1);
        end
        if (cmd.bs_init)
        begin
            lo_next = '0;
            hi_next = cnt_reg;
        end
        if (cmd.bs_step)
        begin
            if (key_reg <= rdata)
            begin
                hi_next = CNT_W'(mid);
            end
            else
            begin
                lo_next = CNT_W'(mid) + CNT_W'(1);
            end
        end
        if (cmd.idx_set)
        begin
            // clamp past the top to the last entry; bottom or top needs no pick
            idx_next    = lo_past_end ? ADDR_W'(cnt_reg - CNT_W'(1)) : ADDR_W'(lo_reg);
            single_next = lo_past_end || (lo_reg == '0);
        end
        if (cmd.cap_a)
        begin
            a_next = rdata;
        end
        if (cmd.res_load)
        begin
            res_status_next = cmd.res_code;
            case (cmd.res_sel)
                RES_RDATA:
                begin
                    res_nearest_next = rdata;
                    res_pos_next     = idx_reg;
                end
                RES_PICK:
                begin
                    if (da < db)
                    begin
                        res_nearest_next = a_reg;
                        res_pos_next     = idx_reg;
                    end
                    else
                    begin
                        res_nearest_next = rdata;
                        res_pos_next     = idx_reg - ADDR_W'(1);
                    end
                end
                default:
                begin
                    res_nearest_next = '0;
                    res_pos_next     = '0;
                end
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            status_next    = res_status_reg;
            nearest_next   = res_nearest_reg;
            pos_next       = POS_W'(res_pos_reg);
            if (res_status_reg == ST_ANSWER)
            begin
                sum_next = SUM_W'(key_reg) + SUM_W'(res_nearest_reg);
            end
            else
            begin
                sum_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        key_reg         <= key_next;
        p_reg           <= p_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        idx_reg         <= idx_next;
        single_reg      <= single_next;
        a_reg           <= a_next;
        res_status_reg  <= res_status_next;
        res_nearest_reg <= res_nearest_next;
        res_pos_reg     <= res_pos_next;
        status_reg      <= status_next;
        nearest_reg     <= nearest_next;
        sum_reg         <= sum_next;
        pos_reg         <= pos_next;
    end

    always_comb
    begin
        sts.kind     = kind_reg;
        sts.cnt_zero = (cnt_reg == '0);
        sts.cnt_full = (cnt_reg == CNT_W'(STORE_DEPTH));
        sts.p_zero   = (p_reg == '0);
        sts.shift_gt = (rdata > key_reg);
        sts.bs_done  = (lo_reg >= hi_reg);
        sts.single   = single_reg;
        sts.out_free = out_free;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign nearest   = nearest_reg;
    assign match_sum = sum_reg;
    assign position  = pos_reg;

endmodule

### tb/tb_nearest_value_match_sum.sv
// Self-checking testbench for nearest_value_match_sum: loads, queries and clears the
// sorted store through the valid/ready channels and compares every result transaction.
// Depends on nvms_pkg and the nearest_value_match_sum RTL.
`timescale 1ns / 100ps

module tb_nearest_value_match_sum;
    import nvms_pkg::*;

    localparam int ITEM_TARGET = 1850;
    localparam int CALM_ITEMS  = 150;
    localparam int FILL_AT     = 500;
    localparam int STALL_LIMIT = 20000;

    // Code 3 is not an operation; the block answers it as a no-op.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        status_t                  status;
        logic signed [VAL_W-1:0]  nearest;
        logic signed [SUM_W-1:0]  match_sum;
        logic [POS_W-1:0]         position;
    } lookup_reply_t;

    class lookup_scoreboard;
        logic signed [VAL_W-1:0] held_values [STORE_DEPTH];
        int unsigned             held_count;
        lookup_reply_t           pending_replies [$];
        int unsigned             faults;

        function new();
            held_count = 0;
            faults     = 0;
        endfunction

        // Update the shadow store and queue the reply this transaction must produce.
        function void note_request(logic [KIND_W-1:0] k, logic signed [VAL_W-1:0] v);
            lookup_reply_t r;
            int unsigned   slot;
            int            d_hi;
            int            d_lo;
            r        = '0;
            r.status = ST_DONE;
            case (k)
                KIND_CLEAR: held_count = 0;
                KIND_LOAD:
                begin
                    if (held_count >= STORE_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        // Insert after any equal values.
                        slot = held_count;
                        while (slot > 0 && held_values[slot-1] > v)
                        begin
                            held_values[slot] = held_values[slot-1];
                            slot--;
                        end
                        held_values[slot] = v;
                        held_count++;
                    end
                end
                KIND_QUERY:
                begin
                    if (held_count == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        slot = 0;
                        while (slot < held_count && held_values[slot] < v)
                            slot++;
                        if (slot == held_count)
                            slot = held_count - 1;
                        else if (slot > 0)
                        begin
                            // Ties go to the lower neighbor.
                            d_hi = int'(held_values[slot]) - int'(v);
                            d_lo = int'(v) - int'(held_values[slot-1]);
                            if (d_lo <= d_hi)
                                slot--;
                        end
                        r.status    = ST_ANSWER;
                        r.nearest   = held_values[slot];
                        r.match_sum = SUM_W'(int'(v) + int'(held_values[slot]));
                        r.position  = POS_W'(slot);
                    end
                end
                default: ;
            endcase
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [STAT_W-1:0] st, logic signed [VAL_W-1:0] nv,
                                  logic signed [SUM_W-1:0] sum, logic [POS_W-1:0] pos);
            lookup_reply_t want;
            if (pending_replies.size() == 0)
            begin
                $error("result with no transaction pending: status %0d", st);
                faults++;
                return;
            end
            want = pending_replies.pop_front();
            if (st !== want.status)
            begin
                $error("status expected %0d got %0d", want.status, st);
                faults++;
            end
            if (nv !== want.nearest)
            begin
                $error("nearest expected %0d got %0d", $signed(want.nearest), nv);
                faults++;
            end
            if (sum !== want.match_sum)
            begin
                $error("match_sum expected %0d got %0d", $signed(want.match_sum), sum);
                faults++;
            end
            if (pos !== want.position)
            begin
                $error("position expected %0d got %0d", want.position, pos);
                faults++;
            end
        endfunction
    endclass

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic [KIND_W-1:0]        kind      = KIND_CLEAR;
    logic signed [VAL_W-1:0]  value     = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [STAT_W-1:0]        status;
    logic signed [VAL_W-1:0]  nearest;
    logic signed [SUM_W-1:0]  match_sum;
    logic [POS_W-1:0]         position;

    lookup_scoreboard board = new();
    int unsigned      sent            = 0;
    bit               sender_idles    = 1'b1;
    bit               receiver_stalls = 1'b1;
    int               stall_left      = 0;
    int               quiet_cycles    = 0;

    nearest_value_match_sum u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .nearest   (nearest),
        .match_sum (match_sum),
        .position  (position)
    );

    always #1 clk = ~clk;

    // Result side: check accepted transactions, stall in random bursts.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_reply(status, nearest, match_sum, position);
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (rst_n && receiver_stalls && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 18) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("tb_nearest_value_match_sum: FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic [KIND_W-1:0] k, input logic signed [VAL_W-1:0] v);
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(k, v);
        sent++;
    endtask

    // Hold the input side until every queued reply has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.pending_replies.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
            1, 2, 3: return VAL_W'(int'($urandom_range(0, 32)) - 16);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Clear, load a handful of values, then query around them.
    task automatic run_sequence();
        logic signed [VAL_W-1:0] loaded [$];
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        logic signed [VAL_W-1:0] v;
        int                      loads;
        int                      queries;
        loads   = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
        queries = $urandom_range(1, 12);
        send_request(KIND_CLEAR, VAL_W'($urandom));
        repeat (loads)
        begin
            v = pick_value();
            loaded.push_back(v);
            send_request(KIND_LOAD, v);
        end
        repeat (queries)
        begin
            a = loaded[$urandom_range(0, loaded.size() - 1)];
            b = loaded[$urandom_range(0, loaded.size() - 1)];
            case ($urandom_range(0, 3))
                0:       v = a;
                1:       v = VAL_W'((int'(a) + int'(b)) >>> 1);
                2:       v = VAL_W'(int'(a) + int'($urandom_range(0, 2)) - 1);
                default: v = pick_value();
            endcase
            send_request(KIND_QUERY, v);
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_request(KIND_W'($urandom_range(0, 3)), pick_value());
    endtask

    // Fill the whole store in ascending order (no shifting), overflow it, query it.
    task automatic fill_store();
        int fill_vals [$];
        send_request(KIND_CLEAR, pick_value());
        repeat (STORE_DEPTH)
            fill_vals.push_back(int'($urandom_range(0, 65535)) - 32768);
        fill_vals.sort();
        foreach (fill_vals[i])
            send_request(KIND_LOAD, VAL_W'(fill_vals[i]));
        send_request(KIND_LOAD, pick_value());
        send_request(KIND_QUERY, 16'sh7FFF);
        send_request(KIND_QUERY, 16'sh8000);
        repeat (16)
            send_request(KIND_QUERY, VAL_W'($urandom));
        send_request(KIND_CLEAR, pick_value());
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(KIND_QUERY, 16'sd0);
        send_request(KIND_UNUSED, 16'sh7FFF);
        send_request(KIND_LOAD, 16'sh7FFF);
        send_request(KIND_LOAD, 16'sh8000);
        send_request(KIND_LOAD, 16'sd0);
        send_request(KIND_LOAD, 16'sd0);
        send_request(KIND_LOAD, 16'sd100);
        send_request(KIND_LOAD, -16'sd100);
        send_request(KIND_QUERY, 16'sh8000);
        send_request(KIND_QUERY, 16'sh7FFF);
        send_request(KIND_QUERY, 16'sd50);
        send_request(KIND_QUERY, 16'sd51);
        send_request(KIND_QUERY, 16'sd0);
        send_request(KIND_QUERY, 16'sd20000);
        send_request(KIND_QUERY, -16'sd16384);
        send_request(KIND_CLEAR, 16'sh8000);
        send_request(KIND_LOAD, -16'sd5);
        send_request(KIND_QUERY, 16'sd1000);
        send_request(KIND_QUERY, -16'sd1000);
        send_request(KIND_CLEAR, 16'sh7FFF);
        send_request(KIND_QUERY, 16'sh8000);
        send_request(KIND_UNUSED, -16'sd1);
        send_request(KIND_LOAD, -16'sd1);
        drain_results();

        while (sent < ITEM_TARGET)
        begin
            if (sent >= ITEM_TARGET - CALM_ITEMS)
            begin
                sender_idles    = 1'b0;
                receiver_stalls = 1'b0;
            end
            else
            begin
                sender_idles    = ($urandom_range(0, 3) != 0);
                receiver_stalls = ($urandom_range(0, 3) != 0);
            end
            if (sent >= FILL_AT && sent < FILL_AT + 100)
                fill_store();
            else if ($urandom_range(0, 5) == 0)
                send_noise();
            else
                run_sequence();
        end
        in_valid <= 1'b0;

        while (board.pending_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.faults == 0)
            $display("tb_nearest_value_match_sum: PASS");
        else
            $display("tb_nearest_value_match_sum: FAIL");
        $finish;
    end

endmodule
